// ----- src/rrfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rrfd_pkg
// Shared types, constants and fixed-point helpers for the rigid rotor
// field derivative pipeline.
// ----------------------------------------------------------------------------
package rrfd_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int WIDE_W    = 2 * WORD_W;
	localparam int PROD_W    = WIDE_W - FRAC_W;
	localparam int INERTIA_W = WORD_W - 1;
	localparam int RATIO_W   = FRAC_W + 1;
	localparam int MAG_W     = WIDE_W - 1 - FRAC_W;
	localparam int RAMP_Q_W  = FRAC_W;
	localparam int ACC_Q_W   = WORD_W;
	localparam int PIPE_LAT  = RAMP_Q_W + ACC_Q_W + 8;
	localparam int REG_IDX_W = 3;
	localparam int IN_DATA_W  = 8 * WORD_W;
	localparam int OUT_DATA_W = 7 * WORD_W;

	localparam logic [REG_IDX_W-1:0] REG_RAMP_START = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RAMP_END   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIPOLE_X   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIPOLE_Y   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DIPOLE_Z   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_INERTIA_X  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_INERTIA_Y  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_INERTIA_Z  = 3'd7;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [INERTIA_W-1:0]     inertia_t;
	typedef logic [RATIO_W-1:0]       ratio_t;
	typedef logic [MAG_W-1:0]         mag_t;

	typedef struct packed {
		word_t w;
		word_t x;
		word_t y;
		word_t z;
	} quat_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} vec_t;

	localparam word_t    WORD_MAX    = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t    WORD_MIN    = {1'b1, {(WORD_W-1){1'b0}}};
	localparam inertia_t INERTIA_ONE = inertia_t'(1) << FRAC_W;
	localparam ratio_t   RATIO_ONE   = ratio_t'(1) << FRAC_W;

	function automatic word_t sat_word(input wide_t v);
		if (v > wide_t'(WORD_MAX))
			return WORD_MAX;
		if (v < wide_t'(WORD_MIN))
			return WORD_MIN;
		return v[WORD_W-1:0];
	endfunction

	// floor(a*b / 2^frac) on the exact product
	function automatic prod_t fmul(input word_t a, input word_t b);
		wide_t p;
		p = a * b;
		return p[WIDE_W-1:FRAC_W];
	endfunction

endpackage

// ----- src/rrfd_quat_rate.sv -----
// ----------------------------------------------------------------------------
// rrfd_quat_rate
// Quaternion kinematic rate 0.5 * (0, w) * q, two register stages.
// ----------------------------------------------------------------------------
module rrfd_quat_rate (
	input  logic           clk,
	input  logic           en,
	input  rrfd_pkg::quat_t q,
	input  rrfd_pkg::vec_t  w,
	output rrfd_pkg::quat_t rate
);
	import rrfd_pkg::*;

	prod_t qx_wx_s2, qy_wy_s2, qz_wz_s2;
	prod_t qw_wx_s2, qz_wy_s2, qy_wz_s2;
	prod_t qz_wx_s2, qw_wy_s2, qx_wz_s2;
	prod_t qy_wx_s2, qx_wy_s2, qw_wz_s2;
	wide_t sum_w, sum_x, sum_y, sum_z;
	quat_t rate_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			qx_wx_s2 <= fmul(q.x, w.x);
			qy_wy_s2 <= fmul(q.y, w.y);
			qz_wz_s2 <= fmul(q.z, w.z);
			qw_wx_s2 <= fmul(q.w, w.x);
			qz_wy_s2 <= fmul(q.z, w.y);
			qy_wz_s2 <= fmul(q.y, w.z);
			qz_wx_s2 <= fmul(q.z, w.x);
			qw_wy_s2 <= fmul(q.w, w.y);
			qx_wz_s2 <= fmul(q.x, w.z);
			qy_wx_s2 <= fmul(q.y, w.x);
			qx_wy_s2 <= fmul(q.x, w.y);
			qw_wz_s2 <= fmul(q.w, w.z);
		end
	end

	always_comb begin
		sum_w = -wide_t'(qx_wx_s2) - wide_t'(qy_wy_s2) - wide_t'(qz_wz_s2);
		sum_x =  wide_t'(qw_wx_s2) + wide_t'(qz_wy_s2) - wide_t'(qy_wz_s2);
		sum_y = -wide_t'(qz_wx_s2) + wide_t'(qw_wy_s2) + wide_t'(qx_wz_s2);
		sum_z =  wide_t'(qy_wx_s2) - wide_t'(qx_wy_s2) + wide_t'(qw_wz_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rate_s3.w <= sat_word(sum_w >>> 1);
			rate_s3.x <= sat_word(sum_x >>> 1);
			rate_s3.y <= sat_word(sum_y >>> 1);
			rate_s3.z <= sat_word(sum_z >>> 1);
		end
	end

	assign rate = rate_s3;

endmodule

// ----- src/rrfd_ramp_div.sv -----
// ----------------------------------------------------------------------------
// rrfd_ramp_div
// Field ramp fraction: pipelined restoring divider, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rrfd_ramp_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [rrfd_pkg::WORD_W-1:0]     dvd,
	input  logic [rrfd_pkg::WORD_W-1:0]     dvs,
	input  logic                            below,
	input  logic                            full,
	output rrfd_pkg::ratio_t                ratio
);
	import rrfd_pkg::*;

	logic [WORD_W-1:0]   rem_s   [RAMP_Q_W];
	logic [RAMP_Q_W-1:0] quo_s   [RAMP_Q_W];
	logic                below_s [RAMP_Q_W];
	logic                full_s  [RAMP_Q_W];

	for (genvar k = 0; k < RAMP_Q_W; k++) begin : g_stage
		logic [WORD_W-1:0]   rem_src;
		logic [RAMP_Q_W-1:0] quo_src;
		logic                below_src;
		logic                full_src;
		logic [WORD_W+1:0]   trial;

		if (k == 0) begin : g_first
			assign rem_src   = dvd;
			assign quo_src   = '0;
			assign below_src = below;
			assign full_src  = full;
		end else begin : g_next
			assign rem_src   = rem_s[k-1];
			assign quo_src   = quo_s[k-1];
			assign below_src = below_s[k-1];
			assign full_src  = full_s[k-1];
		end

		// remainder stays below the divisor, so two extra bits hold the borrow
		assign trial = {1'b0, rem_src, 1'b0} - {2'b00, dvs};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[WORD_W+1]) begin
					rem_s[k] <= trial[WORD_W-1:0];
					quo_s[k] <= {quo_src[RAMP_Q_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= {rem_src[WORD_W-2:0], 1'b0};
					quo_s[k] <= {quo_src[RAMP_Q_W-2:0], 1'b0};
				end
				below_s[k] <= below_src;
				full_s[k]  <= full_src;
			end
		end
	end

	always_comb begin
		if (below_s[RAMP_Q_W-1])
			ratio = '0;
		else if (full_s[RAMP_Q_W-1])
			ratio = RATIO_ONE;
		else
			ratio = {1'b0, quo_s[RAMP_Q_W-1]};
	end

endmodule

// ----- src/rrfd_accel_div.sv -----
// ----------------------------------------------------------------------------
// rrfd_accel_div
// Torque over inertia: pipelined restoring divider on the magnitude, sign
// and saturation applied after the last stage.
// ----------------------------------------------------------------------------
module rrfd_accel_div (
	input  logic              clk,
	input  logic              en,
	input  rrfd_pkg::mag_t     mag,
	input  logic              neg,
	input  rrfd_pkg::inertia_t inertia,
	output rrfd_pkg::word_t    accel
);
	import rrfd_pkg::*;

	localparam int LOW_W = 2 * FRAC_W;

	inertia_t           rem_s [ACC_Q_W];
	logic [LOW_W-1:0]   low_s [ACC_Q_W];
	logic [ACC_Q_W-1:0] quo_s [ACC_Q_W];
	logic               ovf_s [ACC_Q_W];
	logic               neg_s [ACC_Q_W];
	logic [ACC_Q_W-1:0] quo_last;

	for (genvar k = 0; k < ACC_Q_W; k++) begin : g_stage
		inertia_t           rem_src;
		logic [LOW_W-1:0]   low_src;
		logic [ACC_Q_W-1:0] quo_src;
		logic               ovf_src;
		logic               neg_src;
		logic [INERTIA_W:0] cand;
		logic [INERTIA_W+1:0] trial;

		if (k == 0) begin : g_first
			// numerator is mag * 2^frac; its top word must stay below the divisor
			assign rem_src = mag[MAG_W-1:FRAC_W];
			assign low_src = {mag[FRAC_W-1:0], {FRAC_W{1'b0}}};
			assign quo_src = '0;
			assign ovf_src = (mag[MAG_W-1:FRAC_W] >= inertia);
			assign neg_src = neg;
		end else begin : g_next
			assign rem_src = rem_s[k-1];
			assign low_src = low_s[k-1];
			assign quo_src = quo_s[k-1];
			assign ovf_src = ovf_s[k-1];
			assign neg_src = neg_s[k-1];
		end

		assign cand  = {rem_src, low_src[LOW_W-1]};
		assign trial = {1'b0, cand} - {2'b00, inertia};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[INERTIA_W+1]) begin
					rem_s[k] <= trial[INERTIA_W-1:0];
					quo_s[k] <= {quo_src[ACC_Q_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= cand[INERTIA_W-1:0];
					quo_s[k] <= {quo_src[ACC_Q_W-2:0], 1'b0};
				end
				low_s[k] <= {low_src[LOW_W-2:0], 1'b0};
				ovf_s[k] <= ovf_src;
				neg_s[k] <= neg_src;
			end
		end
	end

	assign quo_last = quo_s[ACC_Q_W-1];

	always_comb begin
		if (neg_s[ACC_Q_W-1]) begin
			if (ovf_s[ACC_Q_W-1] || (quo_last[ACC_Q_W-1] && (quo_last[ACC_Q_W-2:0] != '0)))
				accel = WORD_MIN;
			else
				accel = word_t'(~quo_last + 1'b1);
		end else begin
			if (ovf_s[ACC_Q_W-1] || quo_last[ACC_Q_W-1])
				accel = WORD_MAX;
			else
				accel = word_t'(quo_last);
		end
	end

endmodule

// ----- src/rigid_rotor_field_derivative.sv -----
// ----------------------------------------------------------------------------
// rigid_rotor_field_derivative
// Time derivative of a rigid rotor state (orientation quaternion and body
// rates) under Euler's equations plus a dipole torque in a ramped field.
//
//  channel | signals                          | content
//  --------+----------------------------------+-------------------------------
//  s_*     | s_tvalid s_tready s_tdata[255:0] | time, quaternion, body rates
//  m_*     | m_tvalid m_tready m_tdata[223:0] | quaternion rates, accelerations
//  cfg_*   | cfg_we cfg_addr cfg_wdata        | ramp, dipole, inertia registers
//
// one transaction per cycle sustained unless the output stalls; the pipeline
// holds the 16-stage ramp divider followed by the 32-stage acceleration divider
// all stages advance together while the output is empty or being taken;
// a stalled output freezes the whole pipeline and holds s_tready low
// reset clears the valid bits and gives the config registers their defaults
// ----------------------------------------------------------------------------
module rigid_rotor_field_derivative (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sim_time, quat_w, quat_x, quat_y, quat_z, omega_x, omega_y, omega_z
	input  logic [rrfd_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// rate_quat_w, rate_quat_x, rate_quat_y, rate_quat_z, accel_x, accel_y, accel_z
	output logic [rrfd_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                               cfg_we,
	input  logic [rrfd_pkg::REG_IDX_W-1:0]     cfg_addr,
	input  logic [rrfd_pkg::WORD_W-1:0]        cfg_wdata
);
	import rrfd_pkg::*;

	logic en;
	logic [PIPE_LAT-1:0] vld_q;

	word_t    ramp_start_q, ramp_end_q;
	vec_t     dipole_q;
	inertia_t inertia_x_q, inertia_y_q, inertia_z_q;
	word_t    diff_yz_q, diff_zx_q, diff_xy_q;
	inertia_t ix_eff, iy_eff, iz_eff;

	word_t t_s1;
	quat_t q_s1;
	vec_t  w_s1;

	prod_t qx_qz_s2, qw_qy_s2, qy_qz_s2, qw_qx_s2;
	prod_t qw_qw_s2, qx_qx_s2, qy_qy_s2, qz_qz_s2;
	prod_t wy_wz_s2, wz_wx_s2, wx_wy_s2;
	logic [WORD_W-1:0] d_s2, den_s2;
	logic below_s2, full_s2;

	vec_t  g_s3, wsat_s3;
	quat_t qrate_s3;
	vec_t  g_dly_q    [RAMP_Q_W-1];
	vec_t  wsat_dly_q [RAMP_Q_W+1];
	quat_t qrate_dly_q [PIPE_LAT-4];

	ratio_t ratio;
	wide_t  fpx_s19, fpy_s19, fpz_s19;
	vec_t   f_s20;
	prod_t  dz_f2_s21, dy_f3_s21, dx_f3_s21, dz_f1_s21, dy_f1_s21, dx_f2_s21;
	prod_t  gyro_x_s21, gyro_y_s21, gyro_z_s21;
	wide_t  num_x_s22, num_y_s22, num_z_s22;
	mag_t   mag_x_s23, mag_y_s23, mag_z_s23;
	logic   neg_x_s23, neg_y_s23, neg_z_s23;
	word_t  acc_x, acc_y, acc_z;
	logic [OUT_DATA_W-1:0] out_s56;

	wide_t  lim;
	assign lim = wide_t'(1) <<< (MAG_W - 1);

	function automatic mag_t clamp_mag(input wide_t v, input wide_t limit);
		wide_t a;
		a = (v < 0) ? -v : v;
		if (a > limit)
			a = limit;
		return a[MAG_W-1:0];
	endfunction

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[PIPE_LAT-1];
	assign m_tdata  = out_s56;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_start_q <= '0;
			ramp_end_q   <= '0;
			dipole_q     <= '0;
			inertia_x_q  <= INERTIA_ONE;
			inertia_y_q  <= INERTIA_ONE;
			inertia_z_q  <= INERTIA_ONE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_RAMP_START: ramp_start_q <= cfg_wdata;
				REG_RAMP_END:   ramp_end_q   <= cfg_wdata;
				REG_DIPOLE_X:   dipole_q.x   <= cfg_wdata;
				REG_DIPOLE_Y:   dipole_q.y   <= cfg_wdata;
				REG_DIPOLE_Z:   dipole_q.z   <= cfg_wdata;
				REG_INERTIA_X:  inertia_x_q  <= cfg_wdata[INERTIA_W-1:0];
				REG_INERTIA_Y:  inertia_y_q  <= cfg_wdata[INERTIA_W-1:0];
				REG_INERTIA_Z:  inertia_z_q  <= cfg_wdata[INERTIA_W-1:0];
				default: ;
			endcase
		end
	end

	// inertia differences follow the registers; the user must change them only while idle (not enforced)
	always_ff @(posedge clk) begin
		diff_yz_q <= word_t'({1'b0, inertia_y_q}) - word_t'({1'b0, inertia_z_q});
		diff_zx_q <= word_t'({1'b0, inertia_z_q}) - word_t'({1'b0, inertia_x_q});
		diff_xy_q <= word_t'({1'b0, inertia_x_q}) - word_t'({1'b0, inertia_y_q});
	end

	// zero moment acts as the smallest one
	assign ix_eff = (inertia_x_q == '0) ? inertia_t'(1) : inertia_x_q;
	assign iy_eff = (inertia_y_q == '0) ? inertia_t'(1) : inertia_y_q;
	assign iz_eff = (inertia_z_q == '0) ? inertia_t'(1) : inertia_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
	end

	// s1: input capture
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= s_tdata[0*WORD_W +: WORD_W];
			q_s1.w <= s_tdata[1*WORD_W +: WORD_W];
			q_s1.x <= s_tdata[2*WORD_W +: WORD_W];
			q_s1.y <= s_tdata[3*WORD_W +: WORD_W];
			q_s1.z <= s_tdata[4*WORD_W +: WORD_W];
			w_s1.x <= s_tdata[5*WORD_W +: WORD_W];
			w_s1.y <= s_tdata[6*WORD_W +: WORD_W];
			w_s1.z <= s_tdata[7*WORD_W +: WORD_W];
		end
	end

	rrfd_quat_rate u_quat_rate (
		.clk  (clk),
		.en   (en),
		.q    (q_s1),
		.w    (w_s1),
		.rate (qrate_s3)
	);

	// s2: field direction and gyroscopic products, ramp operands
	always_ff @(posedge clk) begin
		if (en) begin
			qx_qz_s2 <= fmul(q_s1.x, q_s1.z);
			qw_qy_s2 <= fmul(q_s1.w, q_s1.y);
			qy_qz_s2 <= fmul(q_s1.y, q_s1.z);
			qw_qx_s2 <= fmul(q_s1.w, q_s1.x);
			qw_qw_s2 <= fmul(q_s1.w, q_s1.w);
			qx_qx_s2 <= fmul(q_s1.x, q_s1.x);
			qy_qy_s2 <= fmul(q_s1.y, q_s1.y);
			qz_qz_s2 <= fmul(q_s1.z, q_s1.z);
			wy_wz_s2 <= fmul(w_s1.y, w_s1.z);
			wz_wx_s2 <= fmul(w_s1.z, w_s1.x);
			wx_wy_s2 <= fmul(w_s1.x, w_s1.y);
			d_s2     <= t_s1 - ramp_start_q;
			den_s2   <= ramp_end_q - ramp_start_q;
			below_s2 <= (t_s1 < ramp_start_q);
			full_s2  <= (t_s1 >= ramp_end_q);
		end
	end

	// s3: saturated field direction and rate products
	always_ff @(posedge clk) begin
		if (en) begin
			g_s3.x <= sat_word((wide_t'(qx_qz_s2) + wide_t'(qw_qy_s2)) <<< 1);
			g_s3.y <= sat_word((wide_t'(qy_qz_s2) - wide_t'(qw_qx_s2)) <<< 1);
			g_s3.z <= sat_word(wide_t'(qw_qw_s2) - wide_t'(qx_qx_s2)
				- wide_t'(qy_qy_s2) + wide_t'(qz_qz_s2));
			wsat_s3.x <= sat_word(wide_t'(wy_wz_s2));
			wsat_s3.y <= sat_word(wide_t'(wz_wx_s2));
			wsat_s3.z <= sat_word(wide_t'(wx_wy_s2));
		end
	end

	// delay lines that wait for the ramp divider and the accel divider
	always_ff @(posedge clk) begin
		if (en) begin
			g_dly_q[0]     <= g_s3;
			wsat_dly_q[0]  <= wsat_s3;
			qrate_dly_q[0] <= qrate_s3;
			for (int i = 1; i < RAMP_Q_W - 1; i++)
				g_dly_q[i] <= g_dly_q[i-1];
			for (int i = 1; i < RAMP_Q_W + 1; i++)
				wsat_dly_q[i] <= wsat_dly_q[i-1];
			for (int i = 1; i < PIPE_LAT - 4; i++)
				qrate_dly_q[i] <= qrate_dly_q[i-1];
		end
	end

	rrfd_ramp_div u_ramp_div (
		.clk   (clk),
		.en    (en),
		.dvd   (d_s2),
		.dvs   (den_s2),
		.below (below_s2),
		.full  (full_s2),
		.ratio (ratio)
	);

	// s19: field direction times ramp fraction
	always_ff @(posedge clk) begin
		if (en) begin
			fpx_s19 <= g_dly_q[RAMP_Q_W-2].x * $signed({1'b0, ratio});
			fpy_s19 <= g_dly_q[RAMP_Q_W-2].y * $signed({1'b0, ratio});
			fpz_s19 <= g_dly_q[RAMP_Q_W-2].z * $signed({1'b0, ratio});
		end
	end

	// s20
	always_ff @(posedge clk) begin
		if (en) begin
			f_s20.x <= sat_word(fpx_s19 >>> FRAC_W);
			f_s20.y <= sat_word(fpy_s19 >>> FRAC_W);
			f_s20.z <= sat_word(fpz_s19 >>> FRAC_W);
		end
	end

	// s21: dipole torque and gyroscopic terms
	always_ff @(posedge clk) begin
		if (en) begin
			dz_f2_s21  <= fmul(dipole_q.z, f_s20.y);
			dy_f3_s21  <= fmul(dipole_q.y, f_s20.z);
			dx_f3_s21  <= fmul(dipole_q.x, f_s20.z);
			dz_f1_s21  <= fmul(dipole_q.z, f_s20.x);
			dy_f1_s21  <= fmul(dipole_q.y, f_s20.x);
			dx_f2_s21  <= fmul(dipole_q.x, f_s20.y);
			gyro_x_s21 <= fmul(diff_yz_q, wsat_dly_q[RAMP_Q_W].x);
			gyro_y_s21 <= fmul(diff_zx_q, wsat_dly_q[RAMP_Q_W].y);
			gyro_z_s21 <= fmul(diff_xy_q, wsat_dly_q[RAMP_Q_W].z);
		end
	end

	// s22
	always_ff @(posedge clk) begin
		if (en) begin
			num_x_s22 <= wide_t'(gyro_x_s21) - (wide_t'(dz_f2_s21) - wide_t'(dy_f3_s21));
			num_y_s22 <= wide_t'(gyro_y_s21) - (wide_t'(dx_f3_s21) - wide_t'(dz_f1_s21));
			num_z_s22 <= wide_t'(gyro_z_s21) - (wide_t'(dy_f1_s21) - wide_t'(dx_f2_s21));
		end
	end

	// s23: clamp and split into sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			mag_x_s23 <= clamp_mag(num_x_s22, lim);
			mag_y_s23 <= clamp_mag(num_y_s22, lim);
			mag_z_s23 <= clamp_mag(num_z_s22, lim);
			neg_x_s23 <= num_x_s22 < 0;
			neg_y_s23 <= num_y_s22 < 0;
			neg_z_s23 <= num_z_s22 < 0;
		end
	end

	rrfd_accel_div u_div_x (
		.clk (clk), .en (en), .mag (mag_x_s23), .neg (neg_x_s23),
		.inertia (ix_eff), .accel (acc_x)
	);

	rrfd_accel_div u_div_y (
		.clk (clk), .en (en), .mag (mag_y_s23), .neg (neg_y_s23),
		.inertia (iy_eff), .accel (acc_y)
	);

	rrfd_accel_div u_div_z (
		.clk (clk), .en (en), .mag (mag_z_s23), .neg (neg_z_s23),
		.inertia (iz_eff), .accel (acc_z)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en)
			out_s56 <= {acc_z, acc_y, acc_x,
				qrate_dly_q[PIPE_LAT-5].z, qrate_dly_q[PIPE_LAT-5].y,
				qrate_dly_q[PIPE_LAT-5].x, qrate_dly_q[PIPE_LAT-5].w};
	end

endmodule
